@@ rtl/rpp_pkg.sv @@
`timescale 1ns / 1ps

package rpp_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 25;

	// result queue: one input byte can yield two results
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [7:0]  CMD_REQUEST   = 8'h01;
	localparam logic [7:0]  CMD_RESPONSE  = 8'h02;
	localparam logic [7:0]  RIP_VERSION   = 8'h02;
	localparam logic [15:0] FAMILY_INET   = 16'h0002;
	localparam logic [15:0] FAMILY_NONE   = 16'h0000;
	localparam logic [15:0] ZERO_FIELD    = 16'h0000;
	localparam logic [31:0] METRIC_MAX    = 32'd16;
	localparam logic [3:0]  IHL_MASK      = 4'hf;
	localparam int unsigned ENTRY_BYTES   = 20;
	localparam int unsigned UDP_HDR_BYTES = 8;
	localparam int unsigned RIP_HDR_BYTES = 4;

	typedef enum logic [2:0] {
		VERDICT_OK          = 3'd0,
		VERDICT_LENGTH      = 3'd1,
		VERDICT_ZERO_FIELD  = 3'd2,
		VERDICT_CMD_VERSION = 3'd3,
		VERDICT_FAMILY      = 3'd4,
		VERDICT_METRIC      = 3'd5,
		VERDICT_MASK        = 3'd6,
		VERDICT_TOO_MANY    = 3'd7
	} verdict_t;

	typedef enum logic {
		KIND_ENTRY   = 1'b0,
		KIND_VERDICT = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t  item_kind;
		logic [4:0]  entry_index;
		logic [31:0] route_addr;
		logic [31:0] route_mask;
		logic [31:0] next_hop;
		logic [4:0]  route_metric;
		logic [7:0]  rip_command;
		logic [4:0]  entry_count;
		verdict_t    verdict;
		logic        last_result;
	} rpp_result_t;

	typedef logic [7:0] rip_hdr_t [RIP_HDR_BYTES];

	function automatic verdict_t header_check(input rip_hdr_t hdr);
		verdict_t v;
		v = VERDICT_OK;
		if ({hdr[2], hdr[3]} != ZERO_FIELD) begin
			v = VERDICT_ZERO_FIELD;
		end else if (!((hdr[0] == CMD_REQUEST || hdr[0] == CMD_RESPONSE) &&
				hdr[1] == RIP_VERSION)) begin
			v = VERDICT_CMD_VERSION;
		end
		return v;
	endfunction

endpackage

@@ rtl/rpp_if.sv @@
`timescale 1ns / 1ps

interface rpp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rpp_result_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic [4:0]  entry_index;
	logic [31:0] route_addr;
	logic [31:0] route_mask;
	logic [31:0] next_hop;
	logic [4:0]  route_metric;
	logic [7:0]  rip_command;
	logic [4:0]  entry_count;
	logic [2:0]  verdict;
	logic        last_result;

	modport source (output valid, output item_kind, output entry_index, output route_addr,
		output route_mask, output next_hop, output route_metric, output rip_command,
		output entry_count, output verdict, output last_result, input ready);
	modport sink (input valid, input item_kind, input entry_index, input route_addr,
		input route_mask, input next_hop, input route_metric, input rip_command,
		input entry_count, input verdict, input last_result, output ready);
endinterface

@@ rtl/rpp_out_fifo.sv @@
`timescale 1ns / 1ps

module rpp_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_a,
	input  rpp_pkg::rpp_result_t data_a,
	input  logic                push_b,
	input  rpp_pkg::rpp_result_t data_b,
	input  logic                pop,
	output logic                space,
	output logic                valid,
	output rpp_pkg::rpp_result_t head
);

	localparam int unsigned PW = rpp_pkg::FIFO_PTR_W;

	rpp_pkg::rpp_result_t mem_q [rpp_pkg::FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic [PW-1:0] wr_b_ptr;
	logic          do_pop;

	// the second item lands after the first when both arrive together
	assign wr_b_ptr = wr_ptr_q + PW'(push_a);
	assign do_pop   = pop && valid;
	assign valid    = cnt_q != '0;
	assign head     = mem_q[rd_ptr_q];
	assign space    = cnt_q <= (PW+1)'(rpp_pkg::FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_ptr_q] <= data_a;
		end
		if (push_b) begin
			mem_q[wr_b_ptr] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_a) + PW'(push_b);
			rd_ptr_q <= rd_ptr_q + PW'(do_pop);
			cnt_q    <= cnt_q + (PW+1)'(push_a) + (PW+1)'(push_b) - (PW+1)'(do_pop);
		end
	end

endmodule

@@ rtl/rip_packet_parser_unit.sv @@
`timescale 1ns / 1ps

// RIPv2 packet parser. Takes an IPv4/UDP/RIPv2 packet one byte per beat and can accept
// a byte on every cycle; a result can appear as early as the cycle after the byte that
// causes it, and a verdict that shares its byte with an entry follows it in the queue.
// An entry passing its checks, with no earlier failure, is delivered at its last byte, and
// the byte marked last yields a verdict item after it. Results go through a four-deep
// queue; input ready is low while fewer than two queue slots are free, since the final
// byte of a packet can produce both an entry and the verdict. The parser is back at its
// start state right after the last byte, so the next packet can follow without a gap.
module rip_packet_parser_unit #(
	parameter int unsigned MAX_ENTRIES = rpp_pkg::MAX_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rpp_byte_if.sink   pkt,
	rpp_result_if.source route
);

	localparam int unsigned HB = rpp_pkg::RIP_HDR_BYTES;
	localparam int unsigned EB = rpp_pkg::ENTRY_BYTES;

	logic [15:0]      pos_q;
	logic [15:0]      total_q;
	logic [3:0]       hw_q;
	rpp_pkg::rip_hdr_t hdr_q;
	logic [7:0]       ent_q [EB-1];
	rpp_pkg::verdict_t fe_q;
	logic [4:0]       seen_q;
	logic [4:0]       idx_q;
	logic [4:0]       j_q;
	logic [16:0]      ent_end_q;

	logic             beat;
	logic [7:0]       b;
	logic [3:0]       hw_n;
	logic [15:0]      total_n;
	logic [6:0]       hs;
	logic [6:0]       es;
	logic             in_hdr;
	logic             in_ent;
	rpp_pkg::rip_hdr_t hdr_n;
	rpp_pkg::verdict_t hdr_err;
	logic             ent_done;
	logic [15:0]      fam;
	logic [31:0]      metric;
	logic [31:0]      mask_be;
	logic [31:0]      inv;
	logic             fam_ok;
	rpp_pkg::verdict_t ent_err;
	logic             emit;
	rpp_pkg::verdict_t fe_n;
	logic [4:0]       seen_n;
	logic [15:0]      bp_next;
	rpp_pkg::verdict_t final_v;
	rpp_pkg::rpp_result_t ent_item;
	rpp_pkg::rpp_result_t ver_item;
	rpp_pkg::rpp_result_t head;
	logic             space;
	logic             fifo_valid;

	assign beat = pkt.valid && pkt.ready;
	assign b    = pkt.data_byte;

	assign hw_n    = (pos_q == 16'd0) ? (b[3:0] & rpp_pkg::IHL_MASK) : hw_q;
	assign hs      = {1'b0, hw_n, 2'b00} + 7'(rpp_pkg::UDP_HDR_BYTES);
	assign es      = hs + 7'(HB);
	assign in_hdr  = (pos_q >= {9'd0, hs}) && (pos_q < {9'd0, es});
	assign bp_next = (pos_q == 16'hffff) ? pos_q : pos_q + 16'd1;

	always_comb begin
		total_n = total_q;
		if (pos_q == 16'd2) begin
			total_n = {b, total_q[7:0]};
		end else if (pos_q == 16'd3) begin
			total_n = {total_q[15:8], b};
		end
	end

	// rip header start is a multiple of four, so the low position bits pick the byte
	always_comb begin
		hdr_n = hdr_q;
		if (in_hdr) begin
			hdr_n[pos_q[1:0]] = b;
		end
	end

	assign hdr_err = rpp_pkg::header_check(hdr_n);

	// an entry counts only if it ends within the stated total length
	assign in_ent   = (pos_q >= {9'd0, es}) && (ent_end_q <= {1'b0, total_q});
	assign ent_done = in_ent && (fe_q == rpp_pkg::VERDICT_OK) && (j_q == 5'(EB - 1));

	assign fam     = {ent_q[0], ent_q[1]};
	assign metric  = {ent_q[16], ent_q[17], ent_q[18], b};
	assign mask_be = {ent_q[8], ent_q[9], ent_q[10], ent_q[11]};
	assign inv     = ~mask_be;
	assign fam_ok  = (hdr_q[0] == rpp_pkg::CMD_RESPONSE && fam == rpp_pkg::FAMILY_INET) ||
		(hdr_q[0] == rpp_pkg::CMD_REQUEST && fam == rpp_pkg::FAMILY_NONE);

	always_comb begin
		ent_err = rpp_pkg::VERDICT_OK;
		if (idx_q >= 5'(MAX_ENTRIES)) begin
			ent_err = rpp_pkg::VERDICT_TOO_MANY;
		end else if (!fam_ok) begin
			ent_err = rpp_pkg::VERDICT_FAMILY;
		end else if (metric == 32'd0 || metric > rpp_pkg::METRIC_MAX) begin
			ent_err = rpp_pkg::VERDICT_METRIC;
		end else if ((inv & (inv + 32'd1)) != 32'd0) begin
			ent_err = rpp_pkg::VERDICT_MASK;
		end
	end

	assign emit   = ent_done && (ent_err == rpp_pkg::VERDICT_OK);
	assign seen_n = seen_q + 5'(emit);

	always_comb begin
		fe_n = fe_q;
		if (in_hdr && pos_q == {9'd0, es - 7'd1} && fe_q == rpp_pkg::VERDICT_OK) begin
			fe_n = hdr_err;
		end else if (ent_done && ent_err != rpp_pkg::VERDICT_OK) begin
			fe_n = ent_err;
		end
	end

	always_comb begin
		if (total_n > bp_next) begin
			final_v = rpp_pkg::VERDICT_LENGTH;
		end else if (fe_n != rpp_pkg::VERDICT_OK) begin
			final_v = fe_n;
		end else if (bp_next < {9'd0, es}) begin
			final_v = hdr_err;
		end else begin
			final_v = rpp_pkg::VERDICT_OK;
		end
	end

	always_comb begin
		ent_item              = '0;
		ent_item.item_kind    = rpp_pkg::KIND_ENTRY;
		ent_item.entry_index  = idx_q;
		ent_item.route_addr   = {ent_q[7], ent_q[6], ent_q[5], ent_q[4]};
		ent_item.route_mask   = {ent_q[11], ent_q[10], ent_q[9], ent_q[8]};
		ent_item.next_hop     = {ent_q[15], ent_q[14], ent_q[13], ent_q[12]};
		ent_item.route_metric = b[4:0];
		ent_item.rip_command  = hdr_n[0];
		ent_item.entry_count  = seen_n;
		ent_item.verdict      = rpp_pkg::VERDICT_OK;
		ent_item.last_result  = 1'b0;

		ver_item              = '0;
		ver_item.item_kind    = rpp_pkg::KIND_VERDICT;
		ver_item.rip_command  = hdr_n[0];
		ver_item.entry_count  = seen_n;
		ver_item.verdict      = final_v;
		ver_item.last_result  = 1'b1;
	end

	// entry bytes: after nineteen beats slot k holds byte k of the current entry
	always_ff @(posedge clk) begin
		if (beat) begin
			ent_q[EB-2] <= b;
			for (int k = 0; k < EB - 2; k++) begin
				ent_q[k] <= ent_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			total_q   <= '0;
			hw_q      <= '0;
			hdr_q     <= '{default: '0};
			fe_q      <= rpp_pkg::VERDICT_OK;
			seen_q    <= '0;
			idx_q     <= '0;
			j_q       <= '0;
			ent_end_q <= '0;
		end else if (beat) begin
			if (pkt.last_byte) begin
				pos_q     <= '0;
				total_q   <= '0;
				hw_q      <= '0;
				hdr_q     <= '{default: '0};
				fe_q      <= rpp_pkg::VERDICT_OK;
				seen_q    <= '0;
				idx_q     <= '0;
				j_q       <= '0;
				ent_end_q <= '0;
			end else begin
				pos_q   <= bp_next;
				total_q <= total_n;
				hw_q    <= hw_n;
				hdr_q   <= hdr_n;
				fe_q    <= fe_n;
				seen_q  <= seen_n;
				if (pos_q == 16'd0) begin
					j_q       <= '0;
					idx_q     <= '0;
					ent_end_q <= {10'd0, es} + 17'(EB);
				end else if (pos_q >= {9'd0, es} && pos_q != 16'hffff) begin
					// entry slot tracking, frozen once the byte count saturates
					if (j_q == 5'(EB - 1)) begin
						j_q       <= '0;
						idx_q     <= (idx_q == 5'h1f) ? idx_q : idx_q + 5'd1;
						ent_end_q <= ent_end_q + 17'(EB);
					end else begin
						j_q <= j_q + 5'd1;
					end
				end
			end
		end
	end

	assign pkt.ready = space;

	rpp_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (beat && emit),
		.data_a (ent_item),
		.push_b (beat && pkt.last_byte),
		.data_b (ver_item),
		.pop    (route.ready),
		.space  (space),
		.valid  (fifo_valid),
		.head   (head)
	);

	assign route.valid        = fifo_valid;
	assign route.item_kind    = head.item_kind;
	assign route.entry_index  = head.entry_index;
	assign route.route_addr   = head.route_addr;
	assign route.route_mask   = head.route_mask;
	assign route.next_hop     = head.next_hop;
	assign route.route_metric = head.route_metric;
	assign route.rip_command  = head.rip_command;
	assign route.entry_count  = head.entry_count;
	assign route.verdict      = head.verdict;
	assign route.last_result  = head.last_result;

endmodule
